// File: rtl/core/sshq_pkg.sv
// Shared types and constants for the smoothed speed hysteresis qualifier.
// No dependencies; used by every module of the block.
`default_nettype none

package sshq_pkg;

   localparam int POS_WIDTH_DEF   = 24;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int SPEED_W = 25;
   localparam int ALPHA_W = 16;
   localparam int HOLD_W  = 16;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
   localparam logic [HOLD_W-1:0]  DWELL_MAX = {HOLD_W{1'b1}};

   // distance datapath
   localparam int SQ_W   = 2 * SPEED_W + 1;
   localparam int RAD_W  = SQ_W + 1;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 1;
   localparam int ITER_W = $clog2(ROOT_W);

   // EMA datapath
   localparam int INV_W  = ALPHA_W + 1;
   localparam int PROD_W = SPEED_W + INV_W;
   localparam int ACC_W  = PROD_W + 1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SPEED_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD  = 2'd3;

   localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
   localparam logic [SPEED_W-1:0] ENTER_RST = 25'd64;
   localparam logic [SPEED_W-1:0] EXIT_RST  = 25'd32;
   localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd10;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [SPEED_W-1:0] enter_thr;
      logic [SPEED_W-1:0] exit_thr;
      logic [HOLD_W-1:0]  hold;
   } sshq_cfg_type;

   typedef struct packed {
      logic               primed;
      logic               big;
      logic [SPEED_W-1:0] dx;
      logic [SPEED_W-1:0] dy;
   } sshq_item_type;

endpackage

`default_nettype wire

// File: rtl/core/smoothed_speed_hysteresis_qualifier.sv
// Smoothed speed qualifier, top level: configuration registers, front end,
// item queue and back end. Depends on sshq_pkg, sshq_front, sshq_queue, sshq_back.
//
// Usage:
//   Position samples enter through push/full with req_pos_x and req_pos_y.
//   Each sample yields one result on the rsp_ ports, read through empty/pop.
//   Registers (alpha, enter and exit thresholds, hold ticks) are written
//   through valid/ready with csr_index and csr_data; ready is always high.
//   Write them only while no transaction is in flight.
// Processing:
//   A sample is accepted and queued. The back end takes one sample at a
//   time: it squares dx and dy, then runs the square root, which produces
//   one result bit per cycle, then updates the average. A first sample goes
//   straight to the result, and a step of 2^25 or more skips the squares and
//   the root. The queue absorbs short bursts while the back end is busy.
// Reset clears the registers to their defaults, the average, state and
// dwell counter, and empties the queue and result register. When the
// receiver does not pop, the back end holds its finished result, the queue
// fills, and full rises.
`default_nettype none

module smoothed_speed_hysteresis_qualifier #(
   parameter int POS_WIDTH   = sshq_pkg::POS_WIDTH_DEF,
   parameter int QUEUE_DEPTH = sshq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [POS_WIDTH-1:0]        req_pos_x,
   input  logic signed [POS_WIDTH-1:0]        req_pos_y,
   output logic                               empty,
   input  logic                               pop,
   output logic [sshq_pkg::SPEED_W-1:0]       rsp_smoothed_speed,
   output logic                               rsp_moving,
   output logic                               rsp_switched,
   output logic                               rsp_primed,
   input  logic                               valid,
   output logic                               ready,
   input  logic [sshq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sshq_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sshq_pkg::*;

   sshq_cfg_type   cfg_ff;
   sshq_item_type  front_item;
   sshq_item_type  q_item;
   logic           accept;
   logic           q_pop;
   logic           q_empty;

   assign ready  = 1'b1;
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha     <= ALPHA_RST;
         cfg_ff.enter_thr <= ENTER_RST;
         cfg_ff.exit_thr  <= EXIT_RST;
         cfg_ff.hold      <= HOLD_RST;
      end else if (valid) begin
         unique case (csr_index)
            CSR_ALPHA: cfg_ff.alpha     <= csr_data[ALPHA_W-1:0];
            CSR_ENTER: cfg_ff.enter_thr <= csr_data[SPEED_W-1:0];
            CSR_EXIT:  cfg_ff.exit_thr  <= csr_data[SPEED_W-1:0];
            CSR_HOLD:  cfg_ff.hold      <= csr_data[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sshq_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .item   (front_item)
   );

   sshq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_item (front_item),
      .pop     (q_pop),
      .rd_item (q_item),
      .full    (full),
      .empty   (q_empty)
   );

   sshq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .pop            (pop),
      .empty          (empty),
      .smoothed_speed (rsp_smoothed_speed),
      .moving         (rsp_moving),
      .switched       (rsp_switched),
      .primed         (rsp_primed)
   );

endmodule

`default_nettype wire

// File: rtl/core/sshq_front.sv
// Front end: holds the previous position and turns each accepted sample
// into absolute deltas for the back end. Depends on sshq_pkg.
`default_nettype none

module sshq_front #(
   parameter int POS_WIDTH = sshq_pkg::POS_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [POS_WIDTH-1:0]   pos_x,
   input  logic signed [POS_WIDTH-1:0]   pos_y,
   output sshq_pkg::sshq_item_type       item
);
   import sshq_pkg::*;

   localparam int CMP_W = (POS_WIDTH > SPEED_W) ? POS_WIDTH : SPEED_W;

   logic                  have_prev_ff;
   logic [POS_WIDTH-1:0]  prev_x_ff;
   logic [POS_WIDTH-1:0]  prev_y_ff;
   logic [POS_WIDTH-1:0]  dx_abs;
   logic [POS_WIDTH-1:0]  dy_abs;
   logic [CMP_W-1:0]      dx_ext;
   logic [CMP_W-1:0]      dy_ext;

   function automatic logic [POS_WIDTH-1:0] abs_diff(
      input logic [POS_WIDTH-1:0] a,
      input logic [POS_WIDTH-1:0] b
   );
      logic [POS_WIDTH:0] d;
      d = {a[POS_WIDTH-1], a} - {b[POS_WIDTH-1], b};
      if (d[POS_WIDTH]) begin
         d = -d;
      end
      return d[POS_WIDTH-1:0];
   endfunction

   always_comb begin
      dx_abs      = abs_diff(pos_x, prev_x_ff);
      dy_abs      = abs_diff(pos_y, prev_y_ff);
      dx_ext      = CMP_W'(dx_abs);
      dy_ext      = CMP_W'(dy_abs);
      item.primed = have_prev_ff;
      item.big    = (dx_ext > CMP_W'(SPEED_MAX)) || (dy_ext > CMP_W'(SPEED_MAX));
      item.dx     = dx_ext[SPEED_W-1:0];
      item.dy     = dy_ext[SPEED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (accept) begin
         have_prev_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= pos_x;
         prev_y_ff <= pos_y;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/sshq_queue.sv
// Short FIFO between front and back end, one sample item per entry.
// Depends on sshq_pkg.
`default_nettype none

module sshq_queue #(
   parameter int DEPTH = sshq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sshq_pkg::sshq_item_type  wr_item,
   input  logic                     pop,
   output sshq_pkg::sshq_item_type  rd_item,
   output logic                     full,
   output logic                     empty
);
   import sshq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sshq_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sshq_back.sv
// Back end: squares, iterative square root, EMA update, hysteresis with
// minimum dwell, and the result register. Depends on sshq_pkg.
`default_nettype none

module sshq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  sshq_pkg::sshq_cfg_type          cfg,
   input  logic                            q_empty,
   input  sshq_pkg::sshq_item_type         q_item,
   output logic                            q_pop,
   input  logic                            pop,
   output logic                            empty,
   output logic [sshq_pkg::SPEED_W-1:0]    smoothed_speed,
   output logic                            moving,
   output logic                            switched,
   output logic                            primed
);
   import sshq_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQX  = 3'd1;
   localparam logic [2:0] ST_SQY  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_MUL1 = 3'd4;
   localparam logic [2:0] ST_MUL2 = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]          state_ff,    state_in;
   sshq_item_type       item_ff,     item_in;
   logic [SQ_W-1:0]     sum_ff,      sum_in;
   logic [RAD_W-1:0]    rad_ff,      rad_in;
   logic [REM_W-1:0]    rem_ff,      rem_in;
   logic [ROOT_W-1:0]   root_ff,     root_in;
   logic [ITER_W-1:0]   iter_ff,     iter_in;
   logic [SPEED_W-1:0]  raw_ff,      raw_in;
   logic [PROD_W-1:0]   prod_ff,     prod_in;
   logic [SPEED_W-1:0]  avg_ff,      avg_in;
   logic                move_ff,     move_in;
   logic [HOLD_W-1:0]   dwell_ff,    dwell_in;
   logic                out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0]  out_speed_ff;
   logic                out_moving_ff;
   logic                out_switched_ff;
   logic                out_primed_ff;

   logic [SPEED_W-1:0]  mul_op;
   logic [SQ_W-2:0]     sq;
   logic [REM_W+1:0]    rem_sh;
   logic [REM_W+1:0]    trial;
   logic [REM_W+1:0]    rem_diff;
   logic                root_bit;
   logic [REM_W-1:0]    rem_step;
   logic [ROOT_W-1:0]   root_step;
   logic [INV_W-1:0]    inv_alpha;
   logic [ACC_W-1:0]    acc;
   logic [ACC_W-17:0]   acc_sh;
   logic [HOLD_W-1:0]   dwell_inc;
   logic                want;
   logic                do_switch;
   logic                out_load;
   logic                moving_in;

   assign mul_op    = (state_ff == ST_SQX) ? item_ff.dx : item_ff.dy;
   assign sq        = (SQ_W - 1)'(mul_op) * (SQ_W - 1)'(mul_op);

   assign rem_sh    = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign rem_diff  = rem_sh - trial;
   assign root_bit  = (rem_sh >= trial);
   assign rem_step  = root_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
   assign root_step = {root_ff[ROOT_W-2:0], root_bit};

   assign inv_alpha = INV_W'(1 << ALPHA_W) - INV_W'(cfg.alpha);
   assign acc       = ACC_W'(prod_ff) + ACC_W'(raw_ff) * ACC_W'(cfg.alpha)
                    + ACC_W'(1 << (ALPHA_W - 1));
   assign acc_sh    = acc[ACC_W-1:ALPHA_W];

   assign dwell_inc = (dwell_ff == DWELL_MAX) ? dwell_ff : dwell_ff + 1'b1;
   assign want      = move_ff ? (avg_ff > cfg.exit_thr) : (avg_ff > cfg.enter_thr);
   assign do_switch = item_ff.primed && (want != move_ff) && (dwell_inc >= cfg.hold);
   assign moving_in = do_switch ? want : move_ff;
   assign out_load  = (state_ff == ST_DONE) && (!out_valid_ff || pop);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      sum_in       = sum_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      avg_in       = avg_ff;
      move_in      = move_ff;
      dwell_in     = dwell_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (!q_item.primed) begin
                  state_in = ST_DONE;
               end else if (q_item.big) begin
                  raw_in   = SPEED_MAX;
                  state_in = ST_MUL1;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            sum_in   = SQ_W'(sq);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = RAD_W'(sum_ff + SQ_W'(sq));
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            rem_in  = rem_step;
            root_in = root_step;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(ROOT_W - 1)) begin
               raw_in   = root_step[ROOT_W-1] ? SPEED_MAX : root_step[SPEED_W-1:0];
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            prod_in  = PROD_W'(avg_ff) * PROD_W'(inv_alpha);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            avg_in   = (acc_sh > (ACC_W - 16)'(SPEED_MAX)) ? SPEED_MAX
                                                          : acc_sh[SPEED_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               if (item_ff.primed) begin
                  move_in  = moving_in;
                  dwell_in = do_switch ? '0 : dwell_inc;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         move_ff      <= 1'b0;
         dwell_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         move_ff      <= move_in;
         dwell_ff     <= dwell_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      raw_ff  <= raw_in;
      prod_ff <= prod_in;
      if (out_load) begin
         out_speed_ff    <= avg_ff;
         out_moving_ff   <= moving_in;
         out_switched_ff <= do_switch;
         out_primed_ff   <= item_ff.primed;
      end
   end

   assign empty          = !out_valid_ff;
   assign smoothed_speed = out_speed_ff;
   assign moving         = out_moving_ff;
   assign switched       = out_switched_ff;
   assign primed         = out_primed_ff;

`ifndef ASSERT_OFF
   a_root_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (iter_ff < ITER_W'(ROOT_W)))
      else $error("root iteration count out of range");
`endif

`ifndef ASSERT_OFF
   a_switch_clears_dwell: assert property (@(posedge clock) disable iff (reset)
      (out_load && do_switch) |=> (dwell_ff == '0))
      else $error("dwell not cleared on switch");
`endif

`ifndef ASSERT_OFF
   a_move_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (move_ff != $past(move_ff)) |-> $past(out_load && do_switch))
      else $error("state changed without a switch transaction");
`endif

endmodule

`default_nettype wire

// File: tb/tb_smoothed_speed_hysteresis_qualifier.sv
// Self-checking testbench for smoothed_speed_hysteresis_qualifier: directed and random
// position traffic, CSR reprogramming, in-line prediction and per-transaction compare.
// Depends on sshq_pkg and the RTL top level only.
`default_nettype none

module tb_smoothed_speed_hysteresis_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   import sshq_pkg::*;

   localparam int POS_W = POS_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic               moving;
      logic               switched;
      logic               primed;
   } speed_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic empty;
   logic pop = 1'b0;
   logic [SPEED_W-1:0] rsp_smoothed_speed;
   logic rsp_moving;
   logic rsp_switched;
   logic rsp_primed;
   logic valid = 1'b0;
   logic ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   smoothed_speed_hysteresis_qualifier #(.POS_WIDTH(POS_W)) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .empty(empty),
      .pop(pop),
      .rsp_smoothed_speed(rsp_smoothed_speed),
      .rsp_moving(rsp_moving),
      .rsp_switched(rsp_switched),
      .rsp_primed(rsp_primed),
      .valid(valid),
      .ready(ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copy
   logic [ALPHA_W-1:0] cfg_alpha = ALPHA_RST;
   logic [SPEED_W-1:0] cfg_enter = ENTER_RST;
   logic [SPEED_W-1:0] cfg_exit = EXIT_RST;
   logic [HOLD_W-1:0] cfg_hold = HOLD_RST;
   logic have_prev = 1'b0;
   logic signed [POS_W-1:0] prev_x = '0;
   logic signed [POS_W-1:0] prev_y = '0;
   logic [SPEED_W-1:0] avg_speed = '0;
   logic moving_state = 1'b0;
   logic [HOLD_W-1:0] dwell = '0;

   speed_report_type expected_reports[$];
   int fail_count = 0;
   int result_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int pop_stall = 0;
   bit send_quiet = 1'b0;
   bit pop_quiet = 1'b0;

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 13));
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= n) root = cand;
      end
      return root;
   endfunction

   function automatic speed_report_type track_sample(
      input logic signed [POS_W-1:0] x,
      input logic signed [POS_W-1:0] y
   );
      speed_report_type rep;
      longint dx;
      longint dy;
      logic [63:0] raw;
      logic [63:0] acc;
      logic want;
      rep.switched = 1'b0;
      rep.primed = have_prev;
      if (!have_prev) begin
         have_prev = 1'b1;
         prev_x = x;
         prev_y = y;
      end else begin
         dx = longint'(x) - longint'(prev_x);
         dy = longint'(y) - longint'(prev_y);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         prev_x = x;
         prev_y = y;
         if (dx > longint'(SPEED_MAX) || dy > longint'(SPEED_MAX)) begin
            raw = 64'(SPEED_MAX);
         end else begin
            raw = floor_root(64'(dx * dx + dy * dy));
            if (raw > 64'(SPEED_MAX)) raw = 64'(SPEED_MAX);
         end
         acc = 64'(avg_speed) * (64'd65536 - 64'(cfg_alpha)) + raw * 64'(cfg_alpha)
               + 64'd32768;
         acc = acc >> 16;
         if (acc > 64'(SPEED_MAX)) acc = 64'(SPEED_MAX);
         avg_speed = acc[SPEED_W-1:0];
         if (dwell != DWELL_MAX) dwell = dwell + 1'b1;
         want = moving_state ? (avg_speed > cfg_exit) : (avg_speed > cfg_enter);
         if (want != moving_state && dwell >= cfg_hold) begin
            moving_state = want;
            dwell = '0;
            rep.switched = 1'b1;
         end
      end
      rep.speed = avg_speed;
      rep.moving = moving_state;
      return rep;
   endfunction

   task automatic send_sample(input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y);
      repeat (send_gap) @(posedge clock);
      push <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      do @(posedge clock); while (full);
      expected_reports.push_back(track_sample(x, y));
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      send_gap = draw_wait(send_quiet);
      if (send_gap != 0) push <= 1'b0;
   endtask

   task automatic stop_sending();
      if (send_gap == 0) push <= 1'b0;
   endtask

   task automatic program_registers(input logic [ALPHA_W-1:0] alpha_v,
                                    input logic [SPEED_W-1:0] enter_v,
                                    input logic [SPEED_W-1:0] exit_v,
                                    input logic [HOLD_W-1:0] hold_v);
      logic [CSR_DATA_W-1:0] word [4];
      logic [CSR_IDX_W-1:0] idx [4];
      // junk above the 16-bit registers must be dropped
      word[0] = {9'($urandom), alpha_v};
      word[1] = enter_v;
      word[2] = exit_v;
      word[3] = {9'($urandom), hold_v};
      idx[0] = CSR_ALPHA;
      idx[1] = CSR_ENTER;
      idx[2] = CSR_EXIT;
      idx[3] = CSR_HOLD;
      stop_sending();
      while (expected_reports.size() != 0) @(posedge clock);
      valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_data <= word[i];
         do @(posedge clock); while (!ready);
         case (idx[i])
            CSR_ALPHA: cfg_alpha = word[i][ALPHA_W-1:0];
            CSR_ENTER: cfg_enter = word[i][SPEED_W-1:0];
            CSR_EXIT:  cfg_exit = word[i][SPEED_W-1:0];
            CSR_HOLD:  cfg_hold = word[i][HOLD_W-1:0];
            default: ;
         endcase
      end
      valid <= 1'b0;
   endtask

   // Trajectory walk: segments of constant velocity or standstill, with
   // occasional teleports across the full range.
   task automatic run_traffic(input int count, input int span);
      int seg_left;
      int vx;
      int vy;
      int pick;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      seg_left = 0;
      vx = 0;
      vy = 0;
      px = prev_x;
      py = prev_y;
      repeat (count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) begin
               vx = 0;
               vy = 0;
            end else begin
               vx = int'($urandom_range(0, 2 * span)) - span;
               vy = int'($urandom_range(0, 2 * span)) - span;
            end
         end
         seg_left--;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
         end else if (pick < 15) begin
            px = POS_W'(px + vx + int'($urandom_range(0, 2)) - 1);
            py = POS_W'(py + vy + int'($urandom_range(0, 2)) - 1);
         end else begin
            px = POS_W'(px + vx);
            py = POS_W'(py + vy);
         end
         send_sample(px, py);
      end
   endtask

   task automatic test_first_sample();
      send_sample(POS_MIN, POS_MAX);
   endtask

   task automatic test_position_extremes();
      send_sample(POS_MAX, POS_MIN);
      send_sample(POS_MIN, POS_MIN);
      send_sample('0, '0);
      send_sample(POS_MAX, POS_MAX);
      send_sample('1, '1);
      send_sample('0, '0);
   endtask

   task automatic test_alpha_extremes();
      program_registers('0, ENTER_RST, EXIT_RST, HOLD_RST);
      send_sample(POS_MAX, '0);
      send_sample(POS_MIN, POS_MIN);
      send_sample(24'sd1000, -24'sd1000);
      program_registers('1, ENTER_RST, EXIT_RST, HOLD_RST);
      send_sample(24'sd5000, 24'sd3000);
      send_sample(24'sd5000, 24'sd3000);
   endtask

   task automatic test_rounding_residue();
      program_registers(16'd20000, '0, '0, '0);
      send_sample(24'sd5010, 24'sd3000);
      send_sample(24'sd5010, 24'sd3000);
      send_sample(24'sd5010, 24'sd3000);
      send_sample(24'sd5010, 24'sd3000);
   endtask

   task automatic test_zero_hold();
      program_registers('1, 25'd5, 25'd3, '0);
      send_sample(24'sd5110, 24'sd3000);
      send_sample(24'sd5110, 24'sd3000);
      send_sample(24'sd5010, 24'sd3100);
   endtask

   task automatic test_random_traffic();
      logic [SPEED_W-1:0] enter_v;
      program_registers(ALPHA_RST, ENTER_RST, EXIT_RST, HOLD_RST);
      run_traffic(320, 150);
      program_registers('1, 25'd200, 25'd150, '0);
      run_traffic(300, 400);
      enter_v = SPEED_W'($urandom_range(0, 500));
      program_registers(ALPHA_W'($urandom), enter_v,
                        SPEED_W'($urandom_range(0, enter_v)),
                        HOLD_W'($urandom_range(0, 20)));
      run_traffic(300, 600);
      program_registers(16'd300, 25'd1000, 25'd500, 16'd3);
      run_traffic(300, 20000);
      program_registers(ALPHA_W'($urandom), SPEED_MAX, SPEED_MAX, DWELL_MAX);
      run_traffic(150, 3000000);
      program_registers(16'd40000, '0, '0, '0);
      run_traffic(180, 30);
      program_registers(ALPHA_W'($urandom), SPEED_W'($urandom_range(0, 800)),
                        SPEED_W'($urandom_range(0, 800)),
                        HOLD_W'($urandom_range(0, 30)));
      run_traffic(300, 500);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      speed_report_type exp_rep;
      speed_report_type got_rep;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got_rep = '{rsp_smoothed_speed, rsp_moving, rsp_switched, rsp_primed};
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result %0d arrived with nothing expected: %p",
                           result_count, got_rep);
            end else begin
               exp_rep = expected_reports.pop_front();
               if (got_rep.speed !== exp_rep.speed || got_rep.moving !== exp_rep.moving ||
                   got_rep.switched !== exp_rep.switched ||
                   got_rep.primed !== exp_rep.primed) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"result %0d: expected speed %0d moving %b switched %b ",
                               "primed %b, got speed %0d moving %b switched %b primed %b"},
                              result_count, exp_rep.speed, exp_rep.moving,
                              exp_rep.switched, exp_rep.primed, got_rep.speed,
                              got_rep.moving, got_rep.switched, got_rep.primed);
               end
            end
            result_count++;
            if ($urandom_range(0, 39) == 0) pop_quiet = !pop_quiet;
            pop_stall = draw_wait(pop_quiet);
         end
         if (pop_stall > 0) begin
            pop_stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_first_sample();
      test_position_extremes();
      test_alpha_extremes();
      test_rounding_residue();
      test_zero_hold();
      test_random_traffic();
      stop_sending();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
